### rtl/core/ppf_pkg.sv
// Shared types and constants for the polyline path follower.
package ppf_pkg;

  localparam int MAX_POINTS = 128;
  localparam int PTR_W      = $clog2(MAX_POINTS);
  localparam int CFG_W      = 14;

  typedef logic signed [15:0] coord_t;
  typedef logic signed [15:0] dir_t;
  typedef logic [PTR_W-1:0]   seg_t;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_SPEED = 1'b0,
    REG_COUNT = 1'b1
  } reg_idx_t;

  localparam logic signed [13:0] SPEED_RESET = 14'sd102;
  localparam logic [7:0]         COUNT_RESET = 8'd76;

endpackage

### rtl/core/ppf_if.sv
// Request and response channels of the polyline path follower.
interface ppf_req_if;
  logic               valid;
  logic               ready;
  ppf_pkg::cmd_t      command;
  ppf_pkg::seg_t      point_index;
  ppf_pkg::coord_t    point_x;
  ppf_pkg::coord_t    point_y;

  modport source (output valid, command, point_index, point_x, point_y, input ready);
  modport sink   (input valid, command, point_index, point_x, point_y, output ready);
endinterface

interface ppf_rsp_if;
  logic               valid;
  logic               ready;
  ppf_pkg::coord_t    pos_x;
  ppf_pkg::coord_t    pos_y;
  ppf_pkg::dir_t      dir_x;
  ppf_pkg::dir_t      dir_y;
  ppf_pkg::seg_t      segment;

  modport source (output valid, pos_x, pos_y, dir_x, dir_y, segment, input ready);
  modport sink   (input valid, pos_x, pos_y, dir_x, dir_y, segment, output ready);
endinterface

### rtl/core/polyline_path_follower.sv
// Polyline path follower: sequencer around one multiplier, one sqrt and one divider step.
// Load, no-op and zero-speed ticks skip to the result. Restart fetches waypoints 0 and 1,
// takes a square root, then two divisions unless they coincide. A tick that reaches no
// waypoint measures the length left and steps; a crossing tick adds a length per segment
// examined and a new direction (zero on a zero-length segment). One item at a time; the
// result register lets the next item start while one waits. Sync reset clears position,
// direction and segment and sets speed 102, count 76; the waypoint memory is not cleared.
module polyline_path_follower (
  input  logic                       clk,
  input  logic                       rst,
  ppf_req_if.sink                    req,
  ppf_rsp_if.source                  rsp,
  input  logic                       cfg_we,
  input  ppf_pkg::reg_idx_t          cfg_index,
  input  logic [ppf_pkg::CFG_W-1:0]  cfg_data
);
  import ppf_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001, S_FA  = 16'h0002, S_FB  = 16'h0004, S_FC   = 16'h0008,
    S_LA   = 16'h0010, S_LB  = 16'h0020, S_SQX = 16'h0040, S_SQY  = 16'h0080,
    S_SQS  = 16'h0100, S_SQRT= 16'h0200, S_DIV = 16'h0400, S_PD   = 16'h0800,
    S_SC0  = 16'h1000, S_SC1 = 16'h2000, S_SC2 = 16'h4000, S_FIN  = 16'h8000
  } state_t;

  typedef enum logic [2:0] {
    PH_RESTART = 3'b001,
    PH_LEFT    = 3'b010,
    PH_SEG     = 3'b100
  } phase_t;

  state_t              state;
  phase_t              phase;
  logic signed [13:0]  speed;
  logic [7:0]          pcount;
  coord_t              pos_x, pos_y;
  dir_t                dir_x, dir_y;
  seg_t                seg;
  logic                ov;
  coord_t              o_pos_x, o_pos_y;
  dir_t                o_dir_x, o_dir_y;
  seg_t                o_seg;

  seg_t                idx;
  logic                fwd;
  logic [13:0]         t;
  logic [16:0]         left;
  logic [7:0]          cnt;
  coord_t              wa_x, wa_y, wb_x, wb_y, bx, by;
  logic signed [16:0]  dx, dy;
  logic signed [35:0]  prod;
  logic [33:0]         rad, res, bitv;
  logic [16:0]         slen;
  logic [17:0]         rem;
  logic [13:0]         quo;
  logic [3:0]          dcnt;
  logic                dsel;
  logic signed [14:0]  travel;

  logic [31:0]         mem [MAX_POINTS];
  logic [31:0]         mem_q;
  seg_t                rd_addr;

  logic [7:0]          n;
  seg_t                seg_w, ra, rb, la, nxt, prv;
  logic signed [17:0]  mul_a, mul_b;
  logic signed [35:0]  mul_p;
  logic [33:0]         sq_trial;
  logic                sq_ge;
  logic [16:0]         l_now;
  logic [17:0]         div_trial;
  logic                div_ge;
  logic [14:0]         q_now;
  logic [16:0]         abs_dx, abs_dy;
  logic [13:0]         spd_abs, t_rest;
  logic                accept, cross_more, rsp_free;

  function automatic coord_t sat_add(input coord_t b, input logic signed [35:0] p);
    logic [35:0]        mag;
    logic [35:0]        rs;
    logic signed [17:0] r;
    logic signed [17:0] sum;
    mag = p[35] ? 36'(-p) : 36'(p);
    rs  = mag + 36'd8192;
    r   = p[35] ? -$signed({1'b0, rs[30:14]}) : $signed({1'b0, rs[30:14]});
    sum = 18'(b) + r;
    if (sum > 18'sd32767)       sat_add = 16'sh7FFF;
    else if (sum < -18'sd32768) sat_add = 16'sh8000;
    else                        sat_add = sum[15:0];
  endfunction

  // Clamp the count and find neighbors of the current segment
  assign n     = (pcount < 8'd2) ? 8'd2 : (pcount > 8'(MAX_POINTS)) ? 8'(MAX_POINTS) : pcount;
  assign seg_w = ({1'b0, seg} >= n) ? '0 : seg;
  assign nxt   = ({1'b0, idx} + 8'd1 == n) ? '0 : idx + seg_t'(1);
  assign prv   = (idx == '0) ? seg_t'(n - 8'd1) : idx - seg_t'(1);
  assign ra    = (phase == PH_RESTART) ? seg_t'(0) : (fwd ? idx : prv);
  assign rb    = (phase == PH_RESTART) ? seg_t'(1) : (fwd ? nxt : idx);
  assign la    = fwd ? nxt : idx;

  assign accept   = req.valid && req.ready;
  assign rsp_free = !ov || rsp.ready;
  assign spd_abs  = speed[13] ? 14'(-speed) : 14'(speed);
  assign abs_dx   = dx[16] ? 17'(-dx) : 17'(dx);
  assign abs_dy   = dy[16] ? 17'(-dy) : 17'(dy);
  assign t_rest   = t - left[13:0];

  // Square root step
  assign sq_trial = res + bitv;
  assign sq_ge    = rad >= sq_trial;
  assign l_now    = res[16:0];
  assign cross_more = (cnt < n) && ({4'b0, t} > {1'b0, left} + {1'b0, l_now});

  // Division step
  assign div_trial = (dcnt == 4'd0) ? rem : {rem[16:0], 1'b0};
  assign div_ge    = div_trial >= {1'b0, slen};
  assign q_now     = {quo, div_ge};

  // Select shared multiplier operands
  always_comb begin
    unique case (state)
      S_SQX:   begin mul_a = 18'(dx);    mul_b = 18'(dx);     end
      S_SQY:   begin mul_a = 18'(dy);    mul_b = 18'(dy);     end
      S_SC0:   begin mul_a = 18'(dir_x); mul_b = 18'(travel); end
      default: begin mul_a = 18'(dir_y); mul_b = 18'(travel); end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Pick memory read address
  always_comb begin
    unique case (state)
      S_FA:    rd_addr = ra;
      S_FB:    rd_addr = rb;
      default: rd_addr = la;
    endcase
  end

  // Waypoint memory
  always_ff @(posedge clk) begin
    if (accept && req.command == CMD_LOAD) begin
      mem[req.point_index] <= {req.point_x, req.point_y};
    end
    mem_q <= mem[rd_addr];
  end

  // Sequencer and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      phase  <= PH_LEFT;
      speed  <= SPEED_RESET;
      pcount <= COUNT_RESET;
      pos_x  <= '0;
      pos_y  <= '0;
      dir_x  <= '0;
      dir_y  <= '0;
      seg    <= '0;
      ov     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SPEED: speed  <= $signed(cfg_data);
          REG_COUNT: pcount <= cfg_data[7:0];
          default:   ;
        endcase
      end
      if (state == S_FIN && rsp_free) ov <= 1'b1;
      else if (rsp.ready)             ov <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (req.command)
              CMD_TICK: begin
                seg   <= seg_w;
                phase <= PH_LEFT;
                state <= (speed == '0) ? S_FIN : S_LA;
              end
              CMD_RESTART: begin
                phase <= PH_RESTART;
                state <= S_FA;
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_FA:  state <= S_FB;
        S_FB:  state <= S_FC;
        S_FC:  state <= S_SQX;
        S_LA:  state <= S_LB;
        S_LB:  state <= S_SQX;
        S_SQX: state <= S_SQY;
        S_SQY: state <= S_SQS;
        S_SQS: state <= S_SQRT;
        S_SQRT: begin
          if (bitv == '0) begin
            unique case (phase)
              PH_LEFT: begin
                if (l_now > {3'b0, t}) begin
                  state <= S_SC0;
                end else begin
                  phase <= PH_SEG;
                  state <= S_FA;
                end
              end
              PH_SEG: begin
                if (cross_more) state <= S_FA;
                else if (l_now == '0) begin
                  dir_x <= '0;
                  dir_y <= '0;
                  state <= S_PD;
                end else state <= S_DIV;
              end
              default: begin
                if (l_now == '0) begin
                  dir_x <= '0;
                  dir_y <= '0;
                  state <= S_PD;
                end else state <= S_DIV;
              end
            endcase
          end
        end
        S_DIV: begin
          if (dcnt == 4'd14) begin
            if (!dsel) begin
              dir_x <= dx[16] ? -$signed({1'b0, q_now}) : $signed({1'b0, q_now});
            end else begin
              dir_y <= dy[16] ? -$signed({1'b0, q_now}) : $signed({1'b0, q_now});
              state <= S_PD;
            end
          end
        end
        S_PD: begin
          if (phase == PH_RESTART) begin
            pos_x <= wa_x;
            pos_y <= wa_y;
            seg   <= '0;
            state <= S_FIN;
          end else begin
            seg   <= fwd ? idx : prv;
            state <= S_SC0;
          end
        end
        S_SC0: state <= S_SC1;
        S_SC1: begin
          pos_x <= sat_add(bx, prod);
          state <= S_SC2;
        end
        S_SC2: begin
          pos_y <= sat_add(by, prod);
          state <= S_FIN;
        end
        S_FIN: begin
          if (rsp_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_p;
    if (state == S_FIN && rsp_free) begin
      o_pos_x <= pos_x;
      o_pos_y <= pos_y;
      o_dir_x <= dir_x;
      o_dir_y <= dir_y;
      o_seg   <= seg;
    end
    unique case (state)
      S_IDLE: begin
        idx <= seg_w;
        fwd <= !speed[13];
        t   <= spd_abs;
        cnt <= '0;
      end
      S_FB: begin
        wa_x <= mem_q[31:16];
        wa_y <= mem_q[15:0];
      end
      S_FC: begin
        wb_x <= mem_q[31:16];
        wb_y <= mem_q[15:0];
        dx   <= 17'($signed(mem_q[31:16])) - 17'(wa_x);
        dy   <= 17'($signed(mem_q[15:0])) - 17'(wa_y);
      end
      S_LB: begin
        dx <= 17'($signed(mem_q[31:16])) - 17'(pos_x);
        dy <= 17'($signed(mem_q[15:0])) - 17'(pos_y);
      end
      S_SQY: rad <= prod[33:0];
      S_SQS: begin
        rad  <= rad + prod[33:0];
        res  <= '0;
        bitv <= 34'h1_0000_0000;
      end
      S_SQRT: begin
        if (bitv != '0) begin
          if (sq_ge) begin
            rad <= rad - sq_trial;
            res <= (res >> 1) + bitv;
          end else begin
            res <= res >> 1;
          end
          bitv <= bitv >> 2;
        end else begin
          slen <= l_now;
          rem  <= {1'b0, abs_dx};
          quo  <= '0;
          dcnt <= '0;
          dsel <= 1'b0;
          unique case (phase)
            PH_LEFT: begin
              left   <= l_now;
              bx     <= pos_x;
              by     <= pos_y;
              travel <= 15'(speed);
              if (fwd) idx <= nxt;
            end
            PH_SEG: begin
              if (cross_more) begin
                t   <= t - l_now[13:0];
                idx <= fwd ? nxt : prv;
                cnt <= cnt + 8'd1;
              end
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        if (dcnt == 4'd14) begin
          rem  <= {1'b0, abs_dy};
          quo  <= '0;
          dcnt <= '0;
          dsel <= 1'b1;
        end else begin
          rem  <= div_ge ? div_trial - {1'b0, slen} : div_trial;
          quo  <= q_now[13:0];
          dcnt <= dcnt + 4'd1;
        end
      end
      S_PD: begin
        bx     <= fwd ? wa_x : wb_x;
        by     <= fwd ? wa_y : wb_y;
        travel <= fwd ? $signed({1'b0, t_rest}) : -$signed({1'b0, t_rest});
      end
      default: ;
    endcase
  end

  // Drive channels
  assign req.ready   = (state == S_IDLE);
  assign rsp.valid   = ov;
  assign rsp.pos_x   = o_pos_x;
  assign rsp.pos_y   = o_pos_y;
  assign rsp.dir_x   = o_dir_x;
  assign rsp.dir_y   = o_dir_y;
  assign rsp.segment = o_seg;

endmodule

### rtl/core/ppf_checker.sv
// Port-level checks for the polyline path follower, bound into polyline_path_follower.
module ppf_checker (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_ready,
  input logic            rsp_valid,
  input logic            rsp_ready,
  input ppf_pkg::coord_t pos_x,
  input ppf_pkg::coord_t pos_y,
  input ppf_pkg::dir_t   dir_x,
  input ppf_pkg::dir_t   dir_y,
  input ppf_pkg::seg_t   segment
);
  import ppf_pkg::*;

  // Hold a stalled result
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(pos_x) && $stable(pos_y) && $stable(dir_x)
      && $stable(dir_y) && $stable(segment))
    else $error("stalled result changed");

  // Busy right after taking an item
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("ready high after accepting an item");

  // Direction stays a unit vector component
  a_dir_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> dir_x <= 16'sd16384 && dir_x >= -16'sd16384
      && dir_y <= 16'sd16384 && dir_y >= -16'sd16384)
    else $error("direction out of range");

endmodule

bind polyline_path_follower ppf_checker u_ppf_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .pos_x     (rsp.pos_x),
  .pos_y     (rsp.pos_y),
  .dir_x     (rsp.dir_x),
  .dir_y     (rsp.dir_y),
  .segment   (rsp.segment)
);

### sim/polyline_path_follower_test.sv
// Self-checking testbench for the polyline path follower: directed table, then random phases.
module polyline_path_follower_test;
  import ppf_pkg::*;

  typedef struct packed {
    coord_t px;
    coord_t py;
    dir_t   dx;
    dir_t   dy;
    seg_t   sg;
  } path_state_t;

  typedef struct {
    cmd_t        cmd;
    seg_t        idx;
    coord_t      x;
    coord_t      y;
    bit          fixed;
    path_state_t want;
  } plan_row_t;

  localparam int RANDOM_ITEMS = 1250;
  localparam int PHASE_ITEMS  = 40;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  reg_idx_t cfg_index;
  logic [CFG_W-1:0] cfg_data;

  ppf_req_if req ();
  ppf_rsp_if rsp ();

  polyline_path_follower dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req.sink),
    .rsp       (rsp.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow state of the path follower
  longint      wp_x [MAX_POINTS];
  longint      wp_y [MAX_POINTS];
  longint      cur_px, cur_py, cur_dx, cur_dy;
  int unsigned cur_seg;
  logic [13:0] speed_reg;
  logic [7:0]  count_reg;

  path_state_t expected_states[$];
  int          errors;
  int          items_sent;
  int          results_seen;
  int          phases_run;
  bit          no_idle;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #100000000;
    $display("tb: failure");
    $finish;
  end

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint vec_len(longint ddx, longint ddy);
    return longint'(isqrt(longint'(ddx * ddx) + longint'(ddy * ddy)));
  endfunction

  function automatic longint leg_len(int unsigned a, int unsigned b);
    return vec_len(wp_x[b] - wp_x[a], wp_y[b] - wp_y[a]);
  endfunction

  function automatic longint unit_comp(longint d, longint len);
    longint mag;
    mag = ((d < 0) ? -d : d) * 16384 / len;
    return (d < 0) ? -mag : mag;
  endfunction

  function automatic void aim(int unsigned from, int unsigned to);
    longint ddx, ddy, len;
    ddx = wp_x[to] - wp_x[from];
    ddy = wp_y[to] - wp_y[from];
    len = vec_len(ddx, ddy);
    if (len == 0) begin
      cur_dx = 0;
      cur_dy = 0;
    end else begin
      cur_dx = unit_comp(ddx, len);
      cur_dy = unit_comp(ddy, len);
    end
  endfunction

  function automatic longint step_of(longint d, longint span);
    longint p, r;
    p = d * span;
    r = (((p < 0) ? -p : p) + 8192) >>> 14;
    return (p < 0) ? -r : r;
  endfunction

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic void put_on(int unsigned base, longint span);
    cur_px = sat16(wp_x[base] + step_of(cur_dx, span));
    cur_py = sat16(wp_y[base] + step_of(cur_dy, span));
  endfunction

  // Advance the shadow point by one tick
  function automatic void advance_tick();
    longint      spd, left, rest;
    int unsigned n, idx, nx, pv, hops;
    spd = longint'($signed(speed_reg));
    n = count_reg;
    hops = 0;
    if (n < 2) n = 2;
    if (n > MAX_POINTS) n = MAX_POINTS;
    if (cur_seg >= n) cur_seg = 0;
    idx = cur_seg;
    if (spd == 0) return;
    if (spd > 0) begin
      nx = (idx + 1) % n;
      left = vec_len(wp_x[nx] - cur_px, wp_y[nx] - cur_py);
      if (left > spd) begin
        cur_px = sat16(cur_px + step_of(cur_dx, spd));
        cur_py = sat16(cur_py + step_of(cur_dy, spd));
        return;
      end
      idx = nx;
      rest = spd;
      while (hops < n && rest > left + leg_len(idx, (idx + 1) % n)) begin
        rest = rest - leg_len(idx, (idx + 1) % n);
        idx = (idx + 1) % n;
        hops++;
      end
      aim(idx, (idx + 1) % n);
      put_on(idx, rest - left);
      cur_seg = idx;
    end else begin
      left = vec_len(cur_px - wp_x[idx], cur_py - wp_y[idx]);
      if (left > -spd) begin
        cur_px = sat16(cur_px + step_of(cur_dx, spd));
        cur_py = sat16(cur_py + step_of(cur_dy, spd));
        return;
      end
      rest = spd;
      pv = (idx == 0) ? n - 1 : idx - 1;
      while (hops < n && -rest > left + leg_len(pv, idx)) begin
        rest = rest + leg_len(pv, idx);
        idx = pv;
        pv = (idx == 0) ? n - 1 : idx - 1;
        hops++;
      end
      aim(pv, idx);
      put_on(idx, rest + left);
      cur_seg = pv;
    end
  endfunction

  // Apply one command to the shadow state and return the state it leaves
  function automatic path_state_t predict_path(cmd_t cmd, seg_t idx, coord_t x, coord_t y);
    path_state_t s;
    case (cmd)
      CMD_LOAD: begin
        wp_x[idx] = x;
        wp_y[idx] = y;
      end
      CMD_TICK: advance_tick();
      CMD_RESTART: begin
        cur_px = wp_x[0];
        cur_py = wp_y[0];
        aim(0, 1);
        cur_seg = 0;
      end
      default: ;
    endcase
    s.px = coord_t'(cur_px);
    s.py = coord_t'(cur_py);
    s.dx = dir_t'(cur_dx);
    s.dy = dir_t'(cur_dy);
    s.sg = seg_t'(cur_seg);
    return s;
  endfunction

  // Present one item, hold it until accepted, then record what it should produce
  task automatic send_item(cmd_t cmd, seg_t idx, coord_t x, coord_t y,
                           bit fixed = 0, path_state_t want = '0);
    int gap;
    path_state_t s;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.command     <= cmd;
    req.point_index <= idx;
    req.point_x     <= x;
    req.point_y     <= y;
    do @(posedge clk); while (!req.ready);
    s = predict_path(cmd, idx, x, y);
    expected_states.push_back(fixed ? want : s);
    items_sent++;
  endtask

  // Drop valid and hold until every expected item has come back
  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (expected_states.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t r, int val);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= CFG_W'(val);
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    if (r == REG_SPEED) speed_reg = 14'(val);
    else count_reg = 8'(val);
  endtask

  function automatic coord_t pick_coord(int style);
    if (style == 0) return coord_t'($urandom);
    return coord_t'($urandom_range(0, 4096)) - 16'sd2048;
  endfunction

  // Accept results with random stalls and compare with the oldest expectation
  initial begin
    path_state_t want;
    int stall;
    rsp.ready <= 1'b0;
    @(negedge rst);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
      results_seen++;
      if (expected_states.size() == 0) begin
        errors++;
        $display("%0t: unexpected result pos=(%0d,%0d) dir=(%0d,%0d) seg=%0d", $time,
                 rsp.pos_x, rsp.pos_y, rsp.dir_x, rsp.dir_y, rsp.segment);
      end else begin
        want = expected_states.pop_front();
        if (rsp.pos_x !== want.px) begin
          errors++;
          $display("%0t: pos_x expected %0d got %0d", $time, want.px, rsp.pos_x);
        end
        if (rsp.pos_y !== want.py) begin
          errors++;
          $display("%0t: pos_y expected %0d got %0d", $time, want.py, rsp.pos_y);
        end
        if (rsp.dir_x !== want.dx) begin
          errors++;
          $display("%0t: dir_x expected %0d got %0d", $time, want.dx, rsp.dir_x);
        end
        if (rsp.dir_y !== want.dy) begin
          errors++;
          $display("%0t: dir_y expected %0d got %0d", $time, want.dy, rsp.dir_y);
        end
        if (rsp.segment !== want.sg) begin
          errors++;
          $display("%0t: segment expected %0d got %0d", $time, want.sg, rsp.segment);
        end
      end
    end
  end

  // Main sequence
  initial begin
    plan_row_t plan[17];
    path_state_t z;
    int n, style, r, spd, cnt, k;
    z = '0;
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    phases_run = 0;
    no_idle = 0;
    cur_px = 0; cur_py = 0; cur_dx = 0; cur_dy = 0; cur_seg = 0;
    speed_reg = SPEED_RESET;
    count_reg = COUNT_RESET;
    for (int i = 0; i < MAX_POINTS; i++) begin
      wp_x[i] = 0;
      wp_y[i] = 0;
    end
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_SPEED;
    cfg_data <= '0;
    req.valid <= 1'b0;
    req.command <= CMD_NOP;
    req.point_index <= '0;
    req.point_x <= '0;
    req.point_y <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, zero-length segment, then a square for exact arrival
    plan = '{
      '{CMD_NOP,     7'd0,   16'sd0,     16'sd0,     1'b1, z},
      '{CMD_LOAD,    7'd0,   16'sd0,     16'sd0,     1'b1, z},
      '{CMD_LOAD,    7'd1,   16'sd32767, -16'sd32768, 1'b1, z},
      '{CMD_LOAD,    7'd2,   -16'sd32768, 16'sd32767, 1'b1, z},
      '{CMD_LOAD,    7'd3,   16'sd0,     16'sd0,     1'b1, z},
      '{CMD_LOAD,    7'd127, -16'sd32768, -16'sd32768, 1'b1, z},
      '{CMD_RESTART, 7'd0,   16'sd0,     16'sd0,     1'b0, z},
      '{CMD_TICK,    7'd0,   16'sd0,     16'sd0,     1'b0, z},
      '{CMD_TICK,    7'd0,   16'sd0,     16'sd0,     1'b0, z},
      '{CMD_LOAD,    7'd0,   16'sd0,     16'sd0,     1'b0, z},
      '{CMD_LOAD,    7'd1,   16'sd1024,  16'sd0,     1'b0, z},
      '{CMD_LOAD,    7'd2,   16'sd1024,  16'sd1024,  1'b0, z},
      '{CMD_LOAD,    7'd3,   16'sd0,     16'sd1024,  1'b0, z},
      '{CMD_RESTART, 7'd0,   16'sd0,     16'sd0,     1'b1, '{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 7'd0}},
      '{CMD_TICK,    7'd0,   16'sd0,     16'sd0,     1'b0, z},
      '{CMD_TICK,    7'd0,   16'sd0,     16'sd0,     1'b0, z},
      '{CMD_NOP,     7'd5,   16'sd77,    -16'sd77,   1'b0, z}
    };
    write_reg(REG_COUNT, 4);
    write_reg(REG_SPEED, 4096);
    foreach (plan[i]) send_item(plan[i].cmd, plan[i].idx, plan[i].x, plan[i].y,
                                plan[i].fixed, plan[i].want);
    drain();

    // Random phases: new settings, path reload, then mostly ticks
    items_sent = 0;
    k = 0;
    while (items_sent < RANDOM_ITEMS) begin
      drain();
      case (k % 8)
        0: spd = 4096;
        1: spd = -4096;
        2: spd = 0;
        3: spd = (k % 16 == 3) ? 8191 : -8192;
        4: spd = $urandom_range(1, 400);
        5: spd = -int'($urandom_range(1, 400));
        default: spd = int'($urandom_range(0, 8192)) - 4096;
      endcase
      case ($urandom_range(0, 9))
        0: cnt = 128;
        1: cnt = 2;
        2: cnt = $urandom_range(0, 1);
        3: cnt = $urandom_range(129, 255);
        4: cnt = $urandom_range(2, 128);
        default: cnt = $urandom_range(2, 16);
      endcase
      write_reg(REG_SPEED, spd);
      write_reg(REG_COUNT, cnt);
      no_idle = (k % 5 == 3);
      style = $urandom_range(0, 2);
      n = (k == 0) ? MAX_POINTS : ((cnt < 2) ? 2 : (cnt > MAX_POINTS ? MAX_POINTS : cnt));
      // Fill every slot on the first phase so no unwritten slot is ever read
      for (int i = 0; i < n; i++) begin
        if (k != 0 && style == 2 && i > 0 && $urandom_range(0, 2) == 0)
          send_item(CMD_LOAD, seg_t'(i), coord_t'(wp_x[i-1]), coord_t'(wp_y[i-1]));
        else
          send_item(CMD_LOAD, seg_t'(i), pick_coord(k == 0 ? 0 : style & 1),
                    pick_coord(k == 0 ? 0 : style & 1));
      end
      // Skip the restart now and then to leave a segment beyond the new count
      if (k % 4 != 1) send_item(CMD_RESTART, '0, '0, '0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 80) send_item(CMD_TICK, seg_t'($urandom), coord_t'($urandom),
                              coord_t'($urandom));
        else if (r < 88) send_item(CMD_LOAD, seg_t'($urandom), pick_coord(style & 1),
                                   pick_coord(style & 1));
        else if (r < 94) send_item(CMD_RESTART, seg_t'($urandom), coord_t'($urandom),
                                   coord_t'($urandom));
        else send_item(CMD_NOP, seg_t'($urandom), coord_t'($urandom), coord_t'($urandom));
      end
      k++;
      phases_run = k;
    end
    drain();
    repeat (200) @(posedge clk);

    $display("tb: %0d random items over %0d phases, %0d results checked", items_sent,
             phases_run, results_seen);
    $display("tb: speeds and counts swept incl. extremes, zero speed and clamped counts");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
